@@ hdl/pose_time_sync_interpolator_unit_assert.svh @@
// Assertion helpers for the pose sync block.
`ifndef POSE_TIME_SYNC_INTERPOLATOR_UNIT_ASSERT_SVH
`define POSE_TIME_SYNC_INTERPOLATOR_UNIT_ASSERT_SVH

// Condition that holds at every clock edge outside reset.
`define PTI_ASSERT(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("pti assertion failed");

// Antecedent implies consequent in the next cycle.
`define PTI_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pti assertion failed");

`endif

@@ hdl/pti_pkg.sv @@
package pti_pkg;
  localparam int DEPTH = 16;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW    = $clog2(DEPTH + 1);
  localparam int NCOMP = 7;
  localparam int QBASE = 3;
  localparam logic [23:0] MAX_GAP_RESET = 24'd200000;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FEW   = 2'd1,
    ST_EARLY = 2'd2,
    ST_GAP   = 2'd3
  } status_t;

  typedef enum logic {
    KIND_SAMPLE  = 1'b0,
    KIND_REQUEST = 1'b1
  } kind_t;

  typedef logic signed [31:0] comp_t;

  typedef struct packed {
    logic [31:0]             stamp;
    comp_t [NCOMP-1:0]       comp;
  } sample_t;

  typedef struct packed {
    kind_t   kind;
    sample_t data;
  } item_t;

  typedef struct packed {
    status_t           status;
    logic [31:0]       stamp;
    comp_t [NCOMP-1:0] comp;
  } result_t;
endpackage

@@ hdl/pti_front.sv @@
module pti_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic             mode,
  input  pti_pkg::sample_t in_data,
  output logic             q_valid,
  output pti_pkg::item_t   q_item,
  input  logic             q_pop
);
  import pti_pkg::*;

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic       do_push;
  logic       do_pop;

  assign full    = (cnt == 2'd2);
  assign q_valid = (cnt != 2'd0);
  assign q_item  = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      cnt <= cnt + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= '{kind: kind_t'(mode), data: in_data};
    end
  end
endmodule

@@ hdl/pti_div.sv @@
module pti_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [64:0] dividend,
  input  logic [32:0] divisor,
  output logic        done,
  output logic [33:0] quot
);
  localparam int QW = 34;

  logic        busy;
  logic [5:0]  cnt;
  logic [32:0] rem;
  logic [33:0] lo;
  logic [33:0] trial;
  logic [33:0] diff;
  logic        ge;

  // quotient known to fit QW bits, so the high part starts below the divisor
  always_comb begin
    trial = {rem, lo[QW-1]};
    ge    = trial >= {1'b0, divisor};
    diff  = trial - {1'b0, divisor};
  end

  assign quot = lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= 33'(dividend[64:QW]);
        lo   <= dividend[QW-1:0];
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? diff[32:0] : trial[32:0];
        lo  <= {lo[QW-2:0], ge};
        if (cnt == 6'(QW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 6'd1;
        end
      end
    end
  end
endmodule

@@ hdl/pti_sqrt.sv @@
module pti_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);
  logic        busy;
  logic [4:0]  cnt;
  logic [63:0] rad;
  logic [33:0] rem;
  logic [35:0] rsh;
  logic [35:0] trial;
  logic        ge;

  always_comb begin
    rsh   = {rem, rad[63:62]};
    trial = 36'({root, 2'b01});
    ge    = rsh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rad  <= radicand;
        rem  <= '0;
        root <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem  <= ge ? 34'(rsh - trial) : rsh[33:0];
        root <= {root[30:0], ge};
        rad  <= {rad[61:0], 2'b00};
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 5'd1;
        end
      end
    end
  end
endmodule

@@ hdl/pti_engine.sv @@
`include "pose_time_sync_interpolator_unit_assert.svh"

module pti_engine (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [23:0]      cfg_data,
  input  logic             q_valid,
  input  pti_pkg::item_t   q_item,
  output logic             q_pop,
  output logic             out_valid,
  output pti_pkg::result_t out_res,
  input  logic             out_pop
);
  import pti_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_RD_A, S_RD_B, S_RD_C, S_CMP, S_MUL, S_DIV, S_DIV_WAIT,
    S_SQ_MUL, S_SQ_ADD, S_SQRT_START, S_SQRT_WAIT, S_NORM, S_NORM_WAIT, S_EMIT
  } state_t;

  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [FW-1:0] off);
    logic [FW:0] s;
    s = (FW+1)'(base) + (FW+1)'(off);
    if (s >= (FW+1)'(DEPTH)) s = s - (FW+1)'(DEPTH);
    return s[AW-1:0];
  endfunction

  state_t        state;
  logic [23:0]   max_gap;
  logic [AW-1:0] head;
  logic [FW-1:0] fill;
  sample_t       mem [DEPTH];
  sample_t       mem_q;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          do_write;
  logic [31:0]   t;
  sample_t       sa;
  sample_t       sb;
  logic [31:0]   w;
  logic [31:0]   d;
  logic [2:0]    k;
  logic [1:0]    j;
  logic [2:0]    qi;
  logic          neg;
  logic signed [65:0] prod;
  logic signed [32:0] diff;
  logic [64:0]   mag;
  logic [63:0]   sq_reg;
  logic [65:0]   acc;
  logic [32:0]   nrm;
  logic [31:0]   qmag;
  comp_t         qj;
  comp_t         lerp_val;
  result_t       res;
  logic          div_start;
  logic [64:0]   div_dividend;
  logic [32:0]   div_divisor;
  logic          div_done;
  logic [33:0]   div_quot;
  logic          sq_start;
  logic          sq_done;
  logic [31:0]   sq_root;

  pti_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot)
  );

  pti_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (acc[63:0]),
    .done     (sq_done),
    .root     (sq_root)
  );

  always_comb begin
    q_pop    = (state == S_IDLE) && q_valid;
    do_write = q_pop && (q_item.kind == KIND_SAMPLE);
    wr_addr  = wrap_add(head, fill);
    rd_addr  = (state == S_RD_B) ? wrap_add(head, FW'(1)) : head;
    diff     = {sb.comp[k][31], sb.comp[k]} - {sa.comp[k][31], sa.comp[k]};
    mag      = 65'(prod[65] ? -prod : prod);
    qi       = 3'(QBASE) + 3'(j);
    qj       = res.comp[qi];
    qmag     = qj[31] ? 32'(-qj) : 32'(qj);
    lerp_val = sa.comp[k] + (neg ? -div_quot[31:0] : div_quot[31:0]);
  end

  always_ff @(posedge clk) begin
    if (do_write) mem[wr_addr] <= q_item.data;
    mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      max_gap   <= MAX_GAP_RESET;
      head      <= '0;
      fill      <= '0;
      out_valid <= 1'b0;
      div_start <= 1'b0;
      sq_start  <= 1'b0;
    end else begin
      div_start <= 1'b0;
      sq_start  <= 1'b0;
      if (cfg_we) max_gap <= cfg_data;
      if (out_pop && out_valid && state != S_EMIT) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            if (q_item.kind == KIND_SAMPLE) begin
              if (fill == FW'(DEPTH)) head <= wrap_add(head, FW'(1));
              else fill <= fill + FW'(1);
            end else begin
              t     <= q_item.data.stamp;
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          res.status <= ST_FEW;
          res.stamp  <= t;
          res.comp   <= '0;
          state      <= (fill < FW'(2)) ? S_EMIT : S_RD_A;
        end
        S_RD_A: state <= S_RD_B;
        S_RD_B: begin
          sa    <= mem_q;
          state <= S_RD_C;
        end
        S_RD_C: begin
          sb    <= mem_q;
          state <= S_CMP;
        end
        S_CMP: begin
          if (sa.stamp > t) begin
            res.status <= ST_EARLY;
            state      <= S_EMIT;
          end else if (sb.stamp < t) begin
            head  <= wrap_add(head, FW'(1));
            fill  <= fill - FW'(1);
            state <= S_CHECK;
          end else if ((t - sa.stamp > {8'd0, max_gap}) || (sb.stamp - t > {8'd0, max_gap})) begin
            head       <= wrap_add(head, FW'(1));
            fill       <= fill - FW'(1);
            res.status <= ST_GAP;
            state      <= S_EMIT;
          end else begin
            res.status <= ST_OK;
            w          <= t - sa.stamp;
            d          <= sb.stamp - sa.stamp;
            k          <= '0;
            state      <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= diff * $signed({1'b0, w});
          state <= S_DIV;
        end
        S_DIV: begin
          if (d == 32'd0) begin
            res.comp[k] <= sa.comp[k];
            if (k == 3'(NCOMP - 1)) begin
              j     <= '0;
              acc   <= '0;
              state <= S_SQ_MUL;
            end else begin
              k     <= k + 3'd1;
              state <= S_MUL;
            end
          end else begin
            neg          <= prod[65];
            div_dividend <= mag + 65'(d >> 1);
            div_divisor  <= {1'b0, d};
            div_start    <= 1'b1;
            state        <= S_DIV_WAIT;
          end
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            res.comp[k] <= lerp_val;
            if (k == 3'(NCOMP - 1)) begin
              j     <= '0;
              acc   <= '0;
              state <= S_SQ_MUL;
            end else begin
              k     <= k + 3'd1;
              state <= S_MUL;
            end
          end
        end
        S_SQ_MUL: begin
          sq_reg <= 64'(qj) * 64'(qj);
          state  <= S_SQ_ADD;
        end
        S_SQ_ADD: begin
          acc <= acc + 66'(sq_reg);
          if (j == 2'd3) begin
            state <= S_SQRT_START;
          end else begin
            j     <= j + 2'd1;
            state <= S_SQ_MUL;
          end
        end
        S_SQRT_START: begin
          // sum past 64 bits saturates the norm at 2^32
          if (acc[65:64] != 2'd0) begin
            nrm   <= 33'h1_0000_0000;
            j     <= '0;
            state <= S_NORM;
          end else begin
            sq_start <= 1'b1;
            state    <= S_SQRT_WAIT;
          end
        end
        S_SQRT_WAIT: begin
          if (sq_done) begin
            nrm   <= {1'b0, sq_root};
            j     <= '0;
            state <= S_NORM;
          end
        end
        S_NORM: begin
          if (nrm == 33'd0) begin
            res.comp[qi] <= '0;
            if (j == 2'd3) state <= S_EMIT;
            else j <= j + 2'd1;
          end else begin
            neg          <= qj[31];
            div_dividend <= (65'(qmag) << 30) + 65'(nrm >> 1);
            div_divisor  <= nrm;
            div_start    <= 1'b1;
            state        <= S_NORM_WAIT;
          end
        end
        S_NORM_WAIT: begin
          if (div_done) begin
            res.comp[qi] <= neg ? -div_quot[31:0] : div_quot[31:0];
            if (j == 2'd3) begin
              state <= S_EMIT;
            end else begin
              j     <= j + 2'd1;
              state <= S_NORM;
            end
          end
        end
        S_EMIT: begin
          if (!out_valid || out_pop) begin
            out_res   <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PTI_ASSERT(a_fill_bound, clk, rst, fill <= FW'(DEPTH))
  `PTI_ASSERT_NEXT(a_result_held, clk, rst, out_valid && !out_pop, out_valid && $stable(out_res))
  `PTI_ASSERT(a_div_owner, clk, rst, !div_done || state == S_DIV_WAIT || state == S_NORM_WAIT)
endmodule

@@ hdl/pose_time_sync_interpolator_unit.sv @@
// Channel   Direction  Handshake          Contents
// input     in         push / full        mode, stamp, pos_x..z, quat_x..w
// result    out        pop / empty        status, out_stamp, out_pos_*, out_quat_*
// config    in         cfg_we             cfg_data = max_gap
//
// A sample item is stored through the input queue once the engine is idle.
// A request first drops stale samples, then runs the shared serial divider
// for each component (7 lerps, 4 normalizations), with the quaternion squares
// and the bit-serial square root between the lerps and the normalizations.
// Synchronous reset clears the sample fill and restores max_gap to 200000.
// A held result stalls the engine; the two-entry input queue then fills.
module pose_time_sync_interpolator_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               mode,
  input  logic [31:0]        stamp,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] quat_x,
  input  logic signed [31:0] quat_y,
  input  logic signed [31:0] quat_z,
  input  logic signed [31:0] quat_w,
  input  logic               pop,
  output logic               empty,
  output logic [1:0]         status,
  output logic [31:0]        out_stamp,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [31:0] out_quat_x,
  output logic signed [31:0] out_quat_y,
  output logic signed [31:0] out_quat_z,
  output logic signed [31:0] out_quat_w,
  input  logic               cfg_we,
  input  logic [23:0]        cfg_data
);
  import pti_pkg::*;

  sample_t in_data;
  item_t   q_item;
  logic    q_valid;
  logic    q_pop;
  logic    out_valid;
  result_t out_res;

  assign in_data.stamp   = stamp;
  assign in_data.comp[0] = pos_x;
  assign in_data.comp[1] = pos_y;
  assign in_data.comp[2] = pos_z;
  assign in_data.comp[3] = quat_x;
  assign in_data.comp[4] = quat_y;
  assign in_data.comp[5] = quat_z;
  assign in_data.comp[6] = quat_w;

  pti_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .mode    (mode),
    .in_data (in_data),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  pti_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_res   (out_res),
    .out_pop   (pop)
  );

  assign empty      = !out_valid;
  assign status     = out_res.status;
  assign out_stamp  = out_res.stamp;
  assign out_pos_x  = out_res.comp[0];
  assign out_pos_y  = out_res.comp[1];
  assign out_pos_z  = out_res.comp[2];
  assign out_quat_x = out_res.comp[3];
  assign out_quat_y = out_res.comp[4];
  assign out_quat_z = out_res.comp[5];
  assign out_quat_w = out_res.comp[6];
endmodule
